// File: rtl/ffa_pkg.sv
`timescale 1ns / 1ps

package ffa_pkg;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_SPACE    = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_NULL_FREE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ALLOC,
    S_ASPLIT,
    S_FSEEK,
    S_FMERGE,
    S_DONE
  } state_t;

  // widest slot index, for the largest heap
  localparam int SLOT_W = 15;
  // byte positions up to heap end plus a header
  localparam int POS_W = 17;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic [15:0]       wr_data;
  } mem_cmd_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] granted_offset;
  } rsp_t;

endpackage

// File: rtl/ffa_ifs.sv
`timescale 1ns / 1ps

interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] request_size;
  logic [15:0] release_offset;

  modport source (output valid, command, request_size, release_offset, input ready);
  modport sink (input valid, command, request_size, release_offset, output ready);
endinterface

interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] granted_offset;

  modport source (output valid, status, granted_offset, input ready);
  modport sink (input valid, status, granted_offset, output ready);
endinterface

// File: rtl/ffa_heap_mem.sv
`timescale 1ns / 1ps

module ffa_heap_mem #(
  parameter int DEPTH = 32768
) (
  input  logic             clk,
  input  ffa_pkg::mem_cmd_t mem,
  output logic [15:0]      rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [15:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (mem.wr_en) begin
      store[mem.wr_slot[AW-1:0]] <= mem.wr_data;
    end
    if (mem.rd_en) begin
      rd_data <= store[mem.rd_slot[AW-1:0]];
    end
  end

endmodule

// File: rtl/ffa_walker.sv
`timescale 1ns / 1ps

module ffa_walker #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst,
  ffa_req_if.sink           req,
  output logic              res_valid,
  output ffa_pkg::rsp_t     res,
  input  logic              res_ready,
  output ffa_pkg::mem_cmd_t mem,
  input  logic [15:0]       rd_data
);

  localparam int PW = ffa_pkg::POS_W;
  localparam logic [PW-1:0] HEAP_END = PW'(HEAP_BYTES);
  localparam logic [15:0] RESET_HDR = 16'(HEAP_BYTES - 2) & 16'hFFFE;
  localparam logic [PW-1:0] TWO = PW'(2);

  ffa_pkg::state_t state, state_next;
  logic [PW-1:0]   pos, pos_next;
  logic [PW-1:0]   need, need_next;
  logic [15:0]     off, off_next;
  logic [PW-1:0]   msz, msz_next;
  ffa_pkg::rsp_t   res_q, res_next;

  logic [PW-1:0] hsz, pos_p2, pos_adv, adv_p2;
  logic [PW-1:0] rnd, need_in, split_pos, msz_add, merge_nxt, merge_nxt_p2, off_w;
  logic [15:0]   split_sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffa_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
    pos   <= pos_next;
    need  <= need_next;
    off   <= off_next;
    msz   <= msz_next;
    res_q <= res_next;
  end

  always_comb begin
    hsz          = PW'({rd_data[15:1], 1'b0});
    pos_p2       = pos + TWO;
    pos_adv      = pos_p2 + hsz;
    adv_p2       = pos_adv + TWO;
    rnd          = PW'(req.request_size) + PW'(1);
    need_in      = {rnd[PW-1:1], 1'b0};
    if (need_in == '0) begin
      need_in = TWO;
    end
    split_pos    = pos_p2 + need;
    split_sz     = 16'(hsz - need - TWO);
    msz_add      = msz + TWO + hsz;
    merge_nxt    = pos_p2 + msz_add;
    merge_nxt_p2 = merge_nxt + TWO;
    off_w        = PW'(off);

    state_next = state;
    pos_next   = pos;
    need_next  = need;
    off_next   = off;
    msz_next   = msz;
    res_next   = res_q;
    mem        = '0;
    req.ready  = 1'b0;
    res_valid  = 1'b0;

    unique case (state)
      ffa_pkg::S_INIT: begin
        mem.wr_en   = 1'b1;
        mem.wr_slot = '0;
        mem.wr_data = RESET_HDR;
        state_next  = ffa_pkg::S_IDLE;
      end
      ffa_pkg::S_IDLE: begin
        req.ready = 1'b1;
        pos_next  = '0;
        if (req.valid) begin
          if (req.command == ffa_pkg::CMD_FREE) begin
            off_next = req.release_offset;
            if (req.release_offset == 16'd0) begin
              res_next   = '{ffa_pkg::ST_NULL_FREE, 16'd0};
              state_next = ffa_pkg::S_DONE;
            end else if (req.release_offset < 16'd2) begin
              res_next   = '{ffa_pkg::ST_DOUBLE_FREE, 16'd0};
              state_next = ffa_pkg::S_DONE;
            end else begin
              mem.rd_en  = 1'b1;
              state_next = ffa_pkg::S_FSEEK;
            end
          end else begin
            need_next  = need_in;
            mem.rd_en  = 1'b1;
            state_next = ffa_pkg::S_ALLOC;
          end
        end
      end
      ffa_pkg::S_ALLOC: begin
        if (!rd_data[0] && hsz >= need) begin
          res_next = '{ffa_pkg::ST_OK, pos_p2[15:0]};
          mem.wr_en = 1'b1;
          if (hsz > need) begin
            mem.wr_slot = split_pos[15:1];
            mem.wr_data = split_sz;
            state_next  = ffa_pkg::S_ASPLIT;
          end else begin
            mem.wr_slot = pos[15:1];
            mem.wr_data = {need[15:1], 1'b1};
            state_next  = ffa_pkg::S_DONE;
          end
        end else if (adv_p2 <= HEAP_END) begin
          mem.rd_en   = 1'b1;
          mem.rd_slot = pos_adv[15:1];
          pos_next    = pos_adv;
        end else begin
          res_next   = '{ffa_pkg::ST_NO_SPACE, 16'd0};
          state_next = ffa_pkg::S_DONE;
        end
      end
      ffa_pkg::S_ASPLIT: begin
        mem.wr_en   = 1'b1;
        mem.wr_slot = pos[15:1];
        mem.wr_data = {need[15:1], 1'b1};
        state_next  = ffa_pkg::S_DONE;
      end
      ffa_pkg::S_FSEEK: begin
        if (pos_p2 < off_w) begin
          if (adv_p2 <= HEAP_END && adv_p2 <= off_w) begin
            mem.rd_en   = 1'b1;
            mem.rd_slot = pos_adv[15:1];
            pos_next    = pos_adv;
          end else begin
            res_next   = '{ffa_pkg::ST_DOUBLE_FREE, 16'd0};
            state_next = ffa_pkg::S_DONE;
          end
        end else if (pos_p2 != off_w || !rd_data[0]) begin
          res_next   = '{ffa_pkg::ST_DOUBLE_FREE, 16'd0};
          state_next = ffa_pkg::S_DONE;
        end else begin
          res_next = '{ffa_pkg::ST_OK, 16'd0};
          msz_next = hsz;
          if (adv_p2 <= HEAP_END) begin
            mem.rd_en   = 1'b1;
            mem.rd_slot = pos_adv[15:1];
            state_next  = ffa_pkg::S_FMERGE;
          end else begin
            mem.wr_en   = 1'b1;
            mem.wr_slot = pos[15:1];
            mem.wr_data = hsz[15:0];
            state_next  = ffa_pkg::S_DONE;
          end
        end
      end
      ffa_pkg::S_FMERGE: begin
        // rd_data holds the header just past the merged span
        if (rd_data[0]) begin
          mem.wr_en   = 1'b1;
          mem.wr_slot = pos[15:1];
          mem.wr_data = msz[15:0];
          state_next  = ffa_pkg::S_DONE;
        end else begin
          msz_next = msz_add;
          if (merge_nxt_p2 <= HEAP_END) begin
            mem.rd_en   = 1'b1;
            mem.rd_slot = merge_nxt[15:1];
          end else begin
            mem.wr_en   = 1'b1;
            mem.wr_slot = pos[15:1];
            mem.wr_data = msz_add[15:0];
            state_next  = ffa_pkg::S_DONE;
          end
        end
      end
      ffa_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ffa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ffa_pkg::S_IDLE;
      end
    endcase
  end

  assign res = res_q;

endmodule

// File: rtl/first_fit_heap_allocator_core.sv
`timescale 1ns / 1ps
// First-fit heap allocator over an implicit list of 16-bit block headers.
// req (sink): command 0 allocates request_size bytes (rounded up to even,
//   zero taken as two), command 1 frees the block at release_offset.
// rsp (source): one item per request, status and granted_offset.
// The headers live in one single-port-read, single-port-write RAM of
// HEAP_BYTES/2 words with registered read data. Each request walks the
// headers from offset zero, one RAM read per cycle; a null free reads
// none. A split allocate makes its second header write in S_ASPLIT.
// Items are handled one at a time; req.ready is high only while the walker
// is idle, which it re-enters the cycle after its result moves into the
// output register, so a new request is taken only after the walker has
// handed off the last one's result.
// rsp is a one-entry output register: while it waits on rsp.ready the
// walker may accept and process the next request, and holds its result
// until the register frees up.
// After rst the walker writes the initial header in S_INIT (one free
// block spanning the heap) with req.ready low; the rest of the RAM
// is never read before it is written.
module first_fit_heap_allocator_core #(
  parameter int HEAP_BYTES = 65536
) (
  input logic      clk,
  input logic      rst,
  ffa_req_if.sink  req,
  ffa_rsp_if.source rsp
);

  ffa_pkg::mem_cmd_t mem;
  logic [15:0]       rd_data;
  logic              res_valid;
  logic              res_ready;
  ffa_pkg::rsp_t     res;

  logic              out_valid;
  logic [1:0]        out_status;
  logic [15:0]       out_offset;

  ffa_heap_mem #(
    .DEPTH (HEAP_BYTES / 2)
  ) u_mem (
    .clk     (clk),
    .mem     (mem),
    .rd_data (rd_data)
  );

  ffa_walker #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .mem       (mem),
    .rd_data   (rd_data)
  );

  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_status <= res.status;
      out_offset <= res.granted_offset;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.granted_offset = out_offset;

endmodule

// File: sim/heap_alloc_checker.sv
`timescale 1ns / 1ps

module heap_alloc_checker #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic clk,
  ffa_req_if   req,
  ffa_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);

  localparam int SLOTS = HEAP_BYTES / 2;

  logic [15:0]   shadow_hdr [SLOTS];
  ffa_pkg::rsp_t expected_replies [$];
  int            mismatches;

  function automatic int unsigned hdr_at(int unsigned pos);
    return 32'(shadow_hdr[(pos >> 1) % SLOTS]);
  endfunction

  function automatic void hdr_put(int unsigned pos, int unsigned value);
    shadow_hdr[(pos >> 1) % SLOTS] = value[15:0];
  endfunction

  // first-fit walk; splits when bytes remain, whole block on exact fit
  function automatic ffa_pkg::rsp_t predict_grant(logic [15:0] size);
    int unsigned   need;
    int unsigned   pos;
    int unsigned   h;
    int unsigned   sz;
    ffa_pkg::rsp_t r;
    need = (32'(size) + 32'd1) & ~32'd1;
    if (need == 0) begin
      need = 2;
    end
    r.status = ffa_pkg::ST_NO_SPACE;
    r.granted_offset = '0;
    pos = 0;
    while (pos + 2 <= HEAP_BYTES) begin
      h = hdr_at(pos);
      sz = h & ~32'd1;
      if (h[0] == 1'b0 && sz >= need) begin
        if (sz > need) begin
          hdr_put(pos + 2 + need, sz - need - 2);
        end
        hdr_put(pos, need | 32'd1);
        r.status = ffa_pkg::ST_OK;
        r.granted_offset = 16'(pos + 2);
        return r;
      end
      pos += 2 + sz;
    end
    return r;
  endfunction

  // release, then merge forward with the run of free blocks that follows it
  function automatic ffa_pkg::rsp_t predict_release(logic [15:0] offset);
    int unsigned   pos;
    int unsigned   sz;
    int unsigned   nxt;
    int unsigned   nh;
    ffa_pkg::rsp_t r;
    r.granted_offset = '0;
    if (offset == 16'd0) begin
      r.status = ffa_pkg::ST_NULL_FREE;
      return r;
    end
    pos = 0;
    while (pos + 2 <= HEAP_BYTES && pos + 2 < 32'(offset)) begin
      pos += 2 + (hdr_at(pos) & ~32'd1);
    end
    if (pos + 2 != 32'(offset) || pos + 2 > HEAP_BYTES || (hdr_at(pos) & 32'd1) == 0) begin
      r.status = ffa_pkg::ST_DOUBLE_FREE;
      return r;
    end
    sz = hdr_at(pos) & ~32'd1;
    nxt = pos + 2 + sz;
    while (nxt + 2 <= HEAP_BYTES) begin
      nh = hdr_at(nxt);
      if ((nh & 32'd1) != 0) begin
        break;
      end
      sz += 2 + (nh & ~32'd1);
      nxt = pos + 2 + sz;
    end
    hdr_put(pos, sz);
    r.status = ffa_pkg::ST_OK;
    return r;
  endfunction

  initial begin
    mismatches = 0;
    for (int k = 0; k < SLOTS; k++) begin
      shadow_hdr[k] = '0;
    end
    shadow_hdr[0] = 16'(HEAP_BYTES - 2) & 16'hFFFE;
  end

  always @(posedge clk) begin : watch
    ffa_pkg::rsp_t want;
    if (req.valid && req.ready) begin
      if (req.command == ffa_pkg::CMD_FREE) begin
        expected_replies.push_back(predict_release(req.release_offset));
      end else begin
        expected_replies.push_back(predict_grant(req.request_size));
      end
    end
    if (rsp.valid && rsp.ready) begin
      if (expected_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected reply, expected none, got status %0d offset %0d",
                 $time, rsp.status, rsp.granted_offset);
      end else begin
        want = expected_replies.pop_front();
        if (rsp.status !== want.status || rsp.granted_offset !== want.granted_offset) begin
          mismatches++;
          $display("%0t: reply mismatch, expected status %0d offset %0d, got status %0d offset %0d",
                   $time, want.status, want.granted_offset, rsp.status, rsp.granted_offset);
        end
      end
    end
    pending <= expected_replies.size();
    fail_count <= mismatches;
  end

endmodule

// File: sim/first_fit_heap_allocator_core_tb.sv
`timescale 1ns / 1ps

module first_fit_heap_allocator_core_tb;

  localparam int     HEAP_BYTES   = 65536;
  localparam int     RANDOM_ITEMS = 1700;
  localparam int     DRAIN_CYCLES = 64;
  localparam longint CYCLE_LIMIT  = 3_000_000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;

  ffa_req_if req_ch ();
  ffa_rsp_if rsp_ch ();

  first_fit_heap_allocator_core #(
    .HEAP_BYTES(HEAP_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  heap_alloc_checker #(
    .HEAP_BYTES(HEAP_BYTES)
  ) reply_check (
    .clk(clk),
    .req(req_ch),
    .rsp(rsp_ch),
    .fail_count(fail_count),
    .pending(pending)
  );

  longint      cycles = 0;
  int          issued = 0;
  int          steady_left = 0;
  int          n_ok = 0;
  int          n_no_space = 0;
  int          n_double = 0;
  int          n_null = 0;
  logic [15:0] live_offsets [$];
  logic [15:0] recent_releases [$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // granted blocks feed the pool that frees draw from
  always @(posedge clk) begin
    if (rsp_ch.valid && rsp_ch.ready) begin
      case (ffa_pkg::status_t'(rsp_ch.status))
        ffa_pkg::ST_OK: begin
          n_ok++;
          if (rsp_ch.granted_offset != 16'd0) begin
            live_offsets.push_back(rsp_ch.granted_offset);
          end
        end
        ffa_pkg::ST_NO_SPACE:    n_no_space++;
        ffa_pkg::ST_DOUBLE_FREE: n_double++;
        default:                 n_null++;
      endcase
    end
  end

  initial begin : rsp_stall
    int pick;
    forever begin
      rsp_ch.ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(100, 300)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick >= 30) begin
        rsp_ch.ready <= 1'b0;
        repeat (pick < 85 ? $urandom_range(1, 3) : $urandom_range(15, 60)) @(posedge clk);
      end
    end
  end

  task automatic issue_request(input ffa_pkg::cmd_t cmd, input logic [15:0] size,
                               input logic [15:0] offset);
    int pick;
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.command <= cmd;
    req_ch.request_size <= size;
    req_ch.release_offset <= offset;
    do @(posedge clk); while (!req_ch.ready);
    issued++;
    gap = 0;
    if (steady_left > 0) begin
      steady_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        steady_left = $urandom_range(50, 150);
      end else if (pick >= 55) begin
        gap = pick < 88 ? $urandom_range(1, 4) : $urandom_range(12, 50);
      end
    end
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    int          pick;
    int          sel;
    int          free_pct;
    int          idx;
    logic [15:0] off;
    logic [15:0] size;

    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.command <= ffa_pkg::CMD_ALLOC;
    req_ch.request_size <= '0;
    req_ch.release_offset <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // null free, free of a free block, zero and odd sizes
    issue_request(ffa_pkg::CMD_FREE, 16'd0, 16'd0);
    issue_request(ffa_pkg::CMD_FREE, 16'hFFFF, 16'd2);
    issue_request(ffa_pkg::CMD_ALLOC, 16'd0, 16'hFFFF);
    issue_request(ffa_pkg::CMD_ALLOC, 16'd1, 16'd0);
    issue_request(ffa_pkg::CMD_ALLOC, 16'd10, 16'd0);
    issue_request(ffa_pkg::CMD_ALLOC, 16'd20, 16'd0);
    issue_request(ffa_pkg::CMD_ALLOC, 16'd30, 16'd0);
    issue_request(ffa_pkg::CMD_FREE, 16'd0, 16'd22);
    issue_request(ffa_pkg::CMD_FREE, 16'd0, 16'd22);
    // misaligned, mid-payload and top-of-range offsets
    issue_request(ffa_pkg::CMD_FREE, 16'd0, 16'd23);
    issue_request(ffa_pkg::CMD_FREE, 16'd0, 16'd30);
    issue_request(ffa_pkg::CMD_FREE, 16'd0, 16'hFFFF);
    // exact fit, then a split that leaves a zero-size block
    issue_request(ffa_pkg::CMD_ALLOC, 16'd20, 16'd0);
    issue_request(ffa_pkg::CMD_FREE, 16'd0, 16'd22);
    issue_request(ffa_pkg::CMD_ALLOC, 16'd18, 16'd0);
    // forward merges, one across several blocks, one to the heap end
    issue_request(ffa_pkg::CMD_FREE, 16'd0, 16'd10);
    issue_request(ffa_pkg::CMD_FREE, 16'd0, 16'd22);
    issue_request(ffa_pkg::CMD_FREE, 16'd0, 16'd6);
    issue_request(ffa_pkg::CMD_FREE, 16'd0, 16'd44);
    issue_request(ffa_pkg::CMD_ALLOC, 16'd65534, 16'd0);
    issue_request(ffa_pkg::CMD_ALLOC, 16'd65535, 16'd0);
    issue_request(ffa_pkg::CMD_FREE, 16'd0, 16'd2);
    issue_request(ffa_pkg::CMD_ALLOC, 16'd65534, 16'd0);
    issue_request(ffa_pkg::CMD_ALLOC, 16'd2, 16'd0);
    issue_request(ffa_pkg::CMD_FREE, 16'd0, 16'd2);
    drain();
    live_offsets.delete();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 400 == 399) begin
        drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        issue_request(ffa_pkg::cmd_t'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
      end else begin
        free_pct = live_offsets.size() < 4 ? 15 : (live_offsets.size() > 48 ? 75 : 45);
        if ($urandom_range(0, 99) < free_pct) begin
          sel = $urandom_range(0, 99);
          if (sel < 88 && live_offsets.size() > 0) begin
            idx = $urandom_range(0, live_offsets.size() - 1);
            off = live_offsets[idx];
            live_offsets.delete(idx);
            recent_releases.push_back(off);
            if (recent_releases.size() > 16) begin
              void'(recent_releases.pop_front());
            end
          end else if (sel < 94 && recent_releases.size() > 0) begin
            off = recent_releases[$urandom_range(0, recent_releases.size() - 1)];
          end else if (sel < 97) begin
            off = 16'd0;
          end else begin
            off = 16'($urandom_range(1, 65535));
          end
          issue_request(ffa_pkg::CMD_FREE, 16'($urandom), off);
        end else begin
          sel = $urandom_range(0, 99);
          if (sel < 70) begin
            size = 16'($urandom_range(0, 64));
          end else if (sel < 90) begin
            size = 16'($urandom_range(0, 1024));
          end else if (sel < 97) begin
            size = 16'($urandom_range(0, 8192));
          end else begin
            size = 16'($urandom);
          end
          issue_request(ffa_pkg::CMD_ALLOC, size, 16'($urandom));
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d allocate/free requests with random stalls on both channels.", issued);
    $display("Replies: %0d ok, %0d no space, %0d double free, %0d null free.",
             n_ok, n_no_space, n_double, n_null);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ffa_pkg.sv
rtl/ffa_ifs.sv
rtl/ffa_heap_mem.sv
rtl/ffa_walker.sv
rtl/first_fit_heap_allocator_core.sv
sim/heap_alloc_checker.sv
sim/first_fit_heap_allocator_core_tb.sv
